/* rtl/wildcard_byte_pattern_search_assert.svh */
// assertion macros for the wildcard byte pattern search block
// expects a clk and an active-high rst in the scope where a macro is used
`ifndef WILDCARD_BYTE_PATTERN_SEARCH_ASSERT_SVH
`define WILDCARD_BYTE_PATTERN_SEARCH_ASSERT_SVH

`ifndef SYNTHESIS
// property that must hold at every edge outside reset
`define WBPS_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("wbps assertion failed");
// condition in one cycle implies a consequence in the next
`define WBPS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wbps next-cycle assertion failed");
`else
`define WBPS_ASSERT(label, prop)
`define WBPS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

/* rtl/wbps_pkg.sv */
// shared types and constants for the wildcard byte pattern search block
// no dependencies; used by the interfaces, the cell and the top level
`timescale 1ns / 1ps
`default_nettype none

package wbps_pkg;

  localparam int WIN_DEPTH           = 16;
  localparam int MAX_PATTERN_DEFAULT = 16;
  localparam int BYTE_W              = 8;
  localparam int COUNT_W             = 32;
  localparam int LEN_W               = 5;
  localparam int REG_W               = 64;
  localparam int MASK_W              = 16;
  localparam int CFG_INDEX_W         = 2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PATTERN_LOW,
    REG_PATTERN_HIGH,
    REG_WILDCARD_MASK,
    REG_PATTERN_LENGTH
  } cfg_reg_t;

  // shift/clear command broadcast to the cell row
  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

  // signature byte aligned to one window position
  typedef struct packed {
    logic [BYTE_W-1:0] sig;
    logic              care;
  } cell_cmp_t;

endpackage

`default_nettype wire

/* rtl/wbps_stream_if.sv */
// valid/ready channel interfaces for the byte input and the result output
// depends on wbps_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface wbps_in_if;
  import wbps_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface wbps_out_if;
  import wbps_pkg::*;
  logic               valid;
  logic               ready;
  logic               found;
  logic [COUNT_W-1:0] match_offset;

  modport source (output valid, output found, output match_offset, input ready);
  modport sink (input valid, input found, input match_offset, output ready);
endinterface

`default_nettype wire

/* rtl/wildcard_byte_pattern_search.sv */
// wildcard byte pattern search: a row of window cells compares every position in parallel
// a result is registered the cycle after its byte; its path is the cell compare row and
// the offset subtract; one byte per cycle while the output register is empty or taken
// reset: synchronous; clears buffer state and output valid, restores register defaults
// depends on wbps_pkg, wbps_stream_if, wbps_cell and the assert macro header
`timescale 1ns / 1ps
`default_nettype none
`include "wildcard_byte_pattern_search_assert.svh"

module wildcard_byte_pattern_search #(
  parameter int MAX_PATTERN = wbps_pkg::MAX_PATTERN_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  wbps_in_if.sink                          byte_stream,
  wbps_out_if.source                       result,
  input  logic                             cfg_we,
  input  logic [wbps_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [wbps_pkg::REG_W-1:0]       cfg_data
);
  import wbps_pkg::*;

  localparam int NUM_CELLS = (MAX_PATTERN < WIN_DEPTH) ? MAX_PATTERN : WIN_DEPTH;
  localparam int IDX_W     = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
  localparam logic [LEN_W-1:0] CAP = LEN_W'(NUM_CELLS);

  // configuration registers
  logic [REG_W-1:0]  pattern_bytes_low;
  logic [REG_W-1:0]  pattern_bytes_high;
  logic [MASK_W-1:0] wildcard_mask;
  logic [LEN_W-1:0]  pattern_length;

  // buffer state and output register
  logic [COUNT_W-1:0] bytes_seen;
  logic               reported;
  logic               out_valid;
  logic               found_q;
  logic [COUNT_W-1:0] offset_q;

  logic [LEN_W-1:0]   eff_len;
  logic [LEN_W-1:0]   len_m1;
  logic [WIN_DEPTH-1:0][BYTE_W-1:0] sig_bytes;
  logic [LEN_W-1:0]   sig_idx [NUM_CELLS];
  cell_cmp_t          cmp [NUM_CELLS];
  cell_ctrl_t         ctrl;
  logic [BYTE_W-1:0]  chain_data [NUM_CELLS];
  logic               chain_valid [NUM_CELLS];
  logic [NUM_CELLS-1:0] hits;

  logic               in_fire;
  logic               filled;
  logic               match;
  logic               report_match;
  logic               emit;
  logic [COUNT_W-1:0] bytes_seen_next;
  logic [COUNT_W-1:0] offset;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes_low  <= '0;
      pattern_bytes_high <= '0;
      wildcard_mask      <= '0;
      pattern_length     <= LEN_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_PATTERN_LOW:    pattern_bytes_low  <= cfg_data;
        REG_PATTERN_HIGH:   pattern_bytes_high <= cfg_data;
        REG_WILDCARD_MASK:  wildcard_mask      <= cfg_data[MASK_W-1:0];
        REG_PATTERN_LENGTH: pattern_length     <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (pattern_length == '0) begin
      eff_len = LEN_W'(1);
    end else if (pattern_length > CAP) begin
      eff_len = CAP;
    end else begin
      eff_len = pattern_length;
    end
  end

  assign len_m1    = eff_len - LEN_W'(1);
  assign sig_bytes = {pattern_bytes_high, pattern_bytes_low};

  // window position p holds signature byte len-1-p
  always_comb begin
    for (int p = 0; p < NUM_CELLS; p++) begin
      sig_idx[p]  = len_m1 - LEN_W'(p);
      cmp[p].sig  = sig_bytes[sig_idx[p][3:0]];
      cmp[p].care = (LEN_W'(p) < eff_len) && !wildcard_mask[sig_idx[p][3:0]];
    end
  end

  assign in_fire    = byte_stream.valid && byte_stream.ready;
  assign ctrl.shift = in_fire;
  assign ctrl.clear = byte_stream.last_byte;

  assign chain_data[0]  = byte_stream.data_byte;
  assign chain_valid[0] = 1'b1;

  for (genvar p = 0; p < NUM_CELLS; p++) begin : g_cell
    if (p < NUM_CELLS - 1) begin : g_link
      wbps_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .ctrl     (ctrl),
        .cmp      (cmp[p]),
        .data_in  (chain_data[p]),
        .valid_in (chain_valid[p]),
        .data_q   (chain_data[p+1]),
        .valid_q  (chain_valid[p+1]),
        .hit      (hits[p])
      );
    end else begin : g_end
      wbps_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .ctrl     (ctrl),
        .cmp      (cmp[p]),
        .data_in  (chain_data[p]),
        .valid_in (chain_valid[p]),
        .data_q   (),
        .valid_q  (),
        .hit      (hits[p])
      );
    end
  end

  // window is complete once position len-1 will hold a byte of this buffer
  assign filled       = chain_valid[len_m1[IDX_W-1:0]];
  assign match        = filled && (&hits);
  assign report_match = !reported && match;
  assign emit         = report_match || (byte_stream.last_byte && !reported);

  assign bytes_seen_next = (bytes_seen == '1) ? bytes_seen : bytes_seen + COUNT_W'(1);
  assign offset          = bytes_seen - COUNT_W'(len_m1);

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen <= '0;
      reported   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (in_fire) begin
        if (byte_stream.last_byte) begin
          bytes_seen <= '0;
          reported   <= 1'b0;
        end else begin
          bytes_seen <= bytes_seen_next;
          reported   <= reported || match;
        end
        out_valid <= emit;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && emit) begin
      found_q  <= report_match;
      offset_q <= report_match ? offset : '0;
    end
  end

  assign byte_stream.ready   = !out_valid || result.ready;
  assign result.valid        = out_valid;
  assign result.found        = found_q;
  assign result.match_offset = offset_q;

  `WBPS_ASSERT(a_not_found_zero_offset, !(result.valid && !result.found) || (result.match_offset == '0))
  `WBPS_ASSERT(a_reported_needs_bytes, !reported || (bytes_seen != '0))
  `WBPS_ASSERT(a_ready_when_empty, out_valid || byte_stream.ready)
  `WBPS_ASSERT_NEXT(a_last_clears, in_fire && byte_stream.last_byte, (bytes_seen == '0) && !reported)

endmodule

`default_nettype wire

/* rtl/wbps_cell.sv */
// one window position: holds a byte and its fill flag, passes both on each beat
// and compares the byte it is about to hold with its aligned signature byte; uses wbps_pkg
`timescale 1ns / 1ps
`default_nettype none

module wbps_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  wbps_pkg::cell_ctrl_t      ctrl,
  input  wbps_pkg::cell_cmp_t       cmp,
  input  logic [wbps_pkg::BYTE_W-1:0] data_in,
  input  logic                      valid_in,
  output logic [wbps_pkg::BYTE_W-1:0] data_q,
  output logic                      valid_q,
  output logic                      hit
);
  import wbps_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (ctrl.shift) begin
      valid_q <= ctrl.clear ? 1'b0 : valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      data_q <= data_in;
    end
  end

  // compare against the incoming byte so the hit matches the window after this beat
  assign hit = !cmp.care || (data_in == cmp.sig);

endmodule

`default_nettype wire

/* bench/wildcard_byte_pattern_search_tb.sv */
// testbench for the wildcard byte pattern search block: directed and random byte buffers
// checked against an in-bench scan predictor; needs wbps_pkg, the stream interfaces and the rtl
`timescale 1ns / 1ps

module wildcard_byte_pattern_search_tb;
  import wbps_pkg::*;

  localparam int RX_HOLD_CYCLES = 300;
  localparam int SIG_CAP = (MAX_PATTERN_DEFAULT < WIN_DEPTH) ? MAX_PATTERN_DEFAULT : WIN_DEPTH;
  localparam int MAX_BUF = 64;

  typedef struct packed {
    logic               found;
    logic [COUNT_W-1:0] offset;
  } scan_report_t;

  logic clk;
  logic rst;
  logic               cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [REG_W-1:0]   cfg_data;

  wbps_in_if  byte_if ();
  wbps_out_if res_if ();

  wildcard_byte_pattern_search u_dut (
    .clk         (clk),
    .rst         (rst),
    .byte_stream (byte_if),
    .result      (res_if),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  // shadow of the configuration registers
  logic [REG_W-1:0]  sig_lo;
  logic [REG_W-1:0]  sig_hi;
  logic [MASK_W-1:0] sig_wild;
  logic [LEN_W-1:0]  sig_len;

  // shadow of the buffer state
  logic [BYTE_W-1:0]  scan_window [WIN_DEPTH];
  logic [COUNT_W-1:0] scan_count;
  logic               scan_reported;

  scan_report_t pending_reports [$];

  bit no_idle;
  bit hold_req;
  int errors;
  int bytes_sent;
  int reports_checked;
  int found_reports;
  int miss_reports;
  int config_count;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #6_000_000;
    $display("%0t: timeout, %0d reports still pending", $time, pending_reports.size());
    $display("== FAIL ==");
    $finish;
  end

  function automatic int active_len();
    int n;
    n = int'(sig_len);
    if (n == 0) n = 1;
    if (n > SIG_CAP) n = SIG_CAP;
    return n;
  endfunction

  function automatic logic [BYTE_W-1:0] sig_byte(input int k);
    if (k < 8) return sig_lo[8*k +: 8];
    return sig_hi[8*(k-8) +: 8];
  endfunction

  task automatic clear_scan();
    for (int i = 0; i < WIN_DEPTH; i++) scan_window[i] = '0;
    scan_count = '0;
    scan_reported = 1'b0;
  endtask

  // append one expected report to the tail of the queue
  task automatic queue_report(input logic f, input logic [COUNT_W-1:0] off);
    scan_report_t r;
    r.found = f;
    r.offset = off;
    pending_reports = {pending_reports, r};
  endtask

  // one accepted byte: shift the window, compare, queue the report it causes
  task automatic predict_scan(input logic [BYTE_W-1:0] b, input logic l);
    int n;
    logic [COUNT_W-1:0] idx;
    bit hit;
    n = active_len();
    idx = scan_count;
    for (int i = WIN_DEPTH - 1; i > 0; i--) scan_window[i] = scan_window[i-1];
    scan_window[0] = b;
    if (scan_count != '1) scan_count = scan_count + COUNT_W'(1);
    hit = 1'b0;
    if (scan_count >= n) begin
      hit = 1'b1;
      // signature byte j sits n-1-j entries back from the newest
      for (int j = 0; j < n; j++)
        if (!sig_wild[j] && scan_window[n-1-j] != sig_byte(j)) hit = 1'b0;
    end
    if (!scan_reported && hit) begin
      queue_report(1'b1, idx - COUNT_W'(n - 1));
      scan_reported = 1'b1;
      found_reports++;
    end else if (l && !scan_reported) begin
      queue_report(1'b0, '0);
      miss_reports++;
    end
    if (l) clear_scan();
  endtask

  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic l);
    int gap;
    gap = 0;
    if (!no_idle) while ($urandom_range(99) < 7) gap++;
    if (gap > 0) begin
      byte_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_if.valid <= 1'b1;
    byte_if.data_byte <= b;
    byte_if.last_byte <= l;
    @(posedge clk);
    while (!byte_if.ready) @(posedge clk);
    predict_scan(b, l);
    bytes_sent++;
  endtask

  // drop valid and wait until every queued report has come out
  task automatic drain_phase();
    int guard;
    byte_if.valid <= 1'b0;
    guard = 0;
    while (pending_reports.size() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic apply_config(input logic [REG_W-1:0] lo, input logic [REG_W-1:0] hi,
                              input logic [REG_W-1:0] wild, input logic [REG_W-1:0] len);
    cfg_we <= 1'b1;
    cfg_index <= REG_PATTERN_LOW;
    cfg_data <= lo;
    @(posedge clk);
    cfg_index <= REG_PATTERN_HIGH;
    cfg_data <= hi;
    @(posedge clk);
    cfg_index <= REG_WILDCARD_MASK;
    cfg_data <= wild;
    @(posedge clk);
    cfg_index <= REG_PATTERN_LENGTH;
    cfg_data <= len;
    @(posedge clk);
    cfg_we <= 1'b0;
    sig_lo = lo;
    sig_hi = hi;
    sig_wild = wild[MASK_W-1:0];
    sig_len = len[LEN_W-1:0];
    config_count++;
  endtask

  // one buffer: background bytes, mostly with the signature planted once or twice
  task automatic run_buffer();
    logic [BYTE_W-1:0] seq [MAX_BUF];
    int n;
    int blen;
    int pos;
    int plants;
    bit formed;
    n = active_len();
    formed = ($urandom_range(0, 9) < 7);
    if (formed) blen = $urandom_range(n, n + 20);
    else blen = $urandom_range(1, 24);
    if ($urandom_range(0, 19) == 0) blen = MAX_BUF;
    for (int i = 0; i < blen; i++) begin
      // near misses come from bytes of the signature itself
      if ($urandom_range(0, 1) == 0) seq[i] = BYTE_W'($urandom);
      else seq[i] = sig_byte($urandom_range(0, n - 1));
    end
    plants = 0;
    if (formed && blen >= n) plants = ($urandom_range(0, 2) == 0) ? 2 : 1;
    for (int k = 0; k < plants; k++) begin
      pos = $urandom_range(0, blen - n);
      if ($urandom_range(0, 3) == 0) pos = blen - n;
      for (int j = 0; j < n; j++)
        seq[pos + j] = sig_wild[j] ? BYTE_W'($urandom) : sig_byte(j);
    end
    for (int i = 0; i < blen; i++) send_byte(seq[i], i == blen - 1);
  endtask

  task automatic random_config();
    logic [REG_W-1:0] lo;
    logic [REG_W-1:0] hi;
    logic [REG_W-1:0] wild;
    logic [REG_W-1:0] len;
    lo = {$urandom, $urandom};
    hi = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0: lo = '0;
      1: hi = '1;
      default: ;
    endcase
    wild = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: wild[MASK_W-1:0] = '0;
      1: wild[MASK_W-1:0] = '1;
      2: wild[MASK_W-1:0] = MASK_W'($urandom & $urandom & $urandom);
      default: ;
    endcase
    len = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: len[LEN_W-1:0] = LEN_W'(0);
      1: len[LEN_W-1:0] = LEN_W'(1);
      2: len[LEN_W-1:0] = LEN_W'(16);
      3: len[LEN_W-1:0] = LEN_W'($urandom_range(17, 31));
      default: len[LEN_W-1:0] = LEN_W'($urandom_range(1, 16));
    endcase
    apply_config(lo, hi, wild, len);
  endtask

  task automatic test_reset_defaults();
    // length one, signature byte zero
    send_byte(8'h05, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h07, 1'b1);
    send_byte(8'hff, 1'b1);
    drain_phase();
  endtask

  task automatic test_directed_cases();
    // AA, wildcard, CC; the second occurrence must be ignored
    apply_config(64'h0000_0000_00cc_5aaa, '1, 64'h0002, 64'd3);
    send_byte(8'haa, 1'b0);
    send_byte(8'h11, 1'b0);
    send_byte(8'hcc, 1'b0);
    send_byte(8'haa, 1'b0);
    send_byte(8'h22, 1'b0);
    send_byte(8'hcc, 1'b0);
    send_byte(8'h00, 1'b1);
    // buffer shorter than the signature
    send_byte(8'haa, 1'b0);
    send_byte(8'h33, 1'b1);
    drain_phase();
    // zero length behaves as one; match lands on the last byte
    apply_config(64'h0000_0000_0000_00ff, '0, '0, 64'd0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b1);
    drain_phase();
    // oversized length clamps to the full window, all wildcards
    apply_config('1, '1, 64'hffff, 64'd31);
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h80, 1'b1);
    drain_phase();
  endtask

  task automatic test_random_scans(input int budget);
    int stop_at;
    stop_at = bytes_sent + budget;
    while (bytes_sent < stop_at) begin
      random_config();
      repeat ($urandom_range(3, 8)) run_buffer();
      drain_phase();
    end
  endtask

  task automatic test_back_to_back(input int budget);
    int stop_at;
    stop_at = bytes_sent + budget;
    no_idle = 1'b1;
    apply_config({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                 REG_W'($urandom_range(1, 4)));
    while (bytes_sent < stop_at) run_buffer();
    drain_phase();
    no_idle = 1'b0;
  endtask

  task automatic test_backpressure();
    // every one-byte buffer reports, so the output fills while the receiver holds off
    apply_config('0, '0, 64'hffff, 64'd1);
    hold_req = 1'b1;
    repeat (60) send_byte(BYTE_W'($urandom), 1'b1);
    drain_phase();
  endtask

  // receiver side: random stalls, one long hold-off on request
  initial begin
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        res_if.ready <= 1'b0;
        repeat (RX_HOLD_CYCLES - 1) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        res_if.ready <= no_idle || ($urandom_range(99) >= 7);
      end
    end
  end

  always @(posedge clk) begin : check_reports
    scan_report_t want;
    if (!rst && res_if.valid && res_if.ready) begin
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected report, expected none, actual found=%0b offset=%0d",
                 $time, res_if.found, res_if.match_offset);
        errors++;
      end else begin
        want = pending_reports.pop_front();
        if (res_if.found !== want.found) begin
          $display("%0t: found mismatch, expected %0b, actual %0b",
                   $time, want.found, res_if.found);
          errors++;
        end
        if (res_if.match_offset !== want.offset) begin
          $display("%0t: match_offset mismatch, expected %0d, actual %0d",
                   $time, want.offset, res_if.match_offset);
          errors++;
        end
        reports_checked++;
      end
    end
  end

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= REG_PATTERN_LOW;
    cfg_data <= '0;
    byte_if.valid <= 1'b0;
    byte_if.data_byte <= '0;
    byte_if.last_byte <= 1'b0;
    no_idle = 1'b0;
    hold_req = 1'b0;
    errors = 0;
    bytes_sent = 0;
    reports_checked = 0;
    found_reports = 0;
    miss_reports = 0;
    config_count = 0;
    sig_lo = '0;
    sig_hi = '0;
    sig_wild = '0;
    sig_len = LEN_W'(1);
    clear_scan();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_directed_cases();
    test_random_scans(1300);
    test_back_to_back(150);
    test_backpressure();

    drain_phase();
    repeat (8) @(posedge clk);
    if (pending_reports.size() != 0) begin
      $display("%0t: %0d expected reports never arrived", $time, pending_reports.size());
      errors += pending_reports.size();
    end
    $display("scanned %0d bytes under %0d register settings, %0d reports checked",
             bytes_sent, config_count, reports_checked);
    $display("%0d first-match reports, %0d not-found reports, %0d errors",
             found_reports, miss_reports, errors);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
